[design/scfd_pkg.sv]
// Package: types and constants for the sum-checked frame deframer.
`timescale 1ns / 1ps
`default_nettype none

package scfd_pkg;

  localparam logic [7:0]  START_BYTE_0   = 8'h4E;
  localparam logic [7:0]  START_BYTE_1   = 8'h57;
  localparam logic [15:0] PAYLOAD_FIRST  = 16'd11;
  localparam logic [15:0] FUNCTION_INDEX = 16'd8;
  localparam logic [15:0] MIN_LENGTH     = 16'd14;
  localparam logic [15:0] TRAILER_BYTES  = 16'd4;
  localparam logic [15:0] HEADER_END     = 16'd4;

  localparam logic [15:0] TIMEOUT_RESET    = 16'd50;
  localparam logic [15:0] MAX_LENGTH_RESET = 16'd1024;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TIMEOUT_TICKS = 1'b0,
    REG_MAX_LENGTH    = 1'b1
  } cfg_reg_t;

  typedef enum logic [0:0] {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  typedef enum logic [0:0] {
    KIND_PAYLOAD = 1'b0,
    KIND_END     = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_SUM_ERROR  = 2'd1,
    ST_BAD_LENGTH = 2'd2,
    ST_TIMEOUT    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_HEADER = 3'd1,
    PH_BODY   = 3'd2,
    PH_SUM_HI = 3'd3,
    PH_SUM_LO = 3'd4
  } phase_t;

  typedef struct packed {
    logic       op;
    logic [7:0] byte_value;
  } in_word_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [7:0]  function_code;
    logic [1:0]  status;
    logic [15:0] computed_sum;
    logic [15:0] received_sum;
    logic        last;
  } out_word_t;

endpackage

`default_nettype wire

[design/sum_checked_frame_deframer_unit.sv]
// Sum-checked frame deframer: byte/tick input, payload and verdict words out.
// Input channel (in_valid/in_stall/in_data): one word per cycle while in_stall
// is low, either a received byte or one time tick. Output channel (out_valid/out_stall/
// out_data): payload bytes of a frame as they arrive, then one end word
// with last set whose status gives the verdict (ok, checksum mismatch,
// bad length, timeout); the consumer drops a frame whose status is not ok.
// Config port (cfg_we/cfg_index/cfg_data): the user must write timeout_ticks
// and max_length only while the block is idle; the block does not enforce it.
// Path: a word accepted is held in the input register; its result, if any,
// passes the combinational state update into the output register, or into
// the skid slot when that register is held. Throughput: one word per cycle
// while the skid slot is not full, as the state update between input and
// output registers is combinational.
// Reset: deframer idle, counters and sums cleared, timeout_ticks = 50,
// max_length = 1024, both output slots empty.
// Stall: the output register plus one skid slot hold up to two results;
// in_stall rises only when the skid slot is full and a word is waiting.
`timescale 1ns / 1ps
`default_nettype none

module sum_checked_frame_deframer_unit
  import scfd_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire in_word_t               in_data,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output out_word_t                   out_data,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [15:0] timeout_ticks;
  logic [15:0] max_length;

  logic        s1_valid;
  in_word_t    s1_data;

  logic        k_valid;
  out_word_t   k_data;

  phase_t      phase, phase_next;
  logic [15:0] byte_index, byte_index_next;
  logic [15:0] frame_length, frame_length_next;
  logic [15:0] running_sum, running_sum_next;
  logic [7:0]  sum_high_byte, sum_high_byte_next;
  logic [7:0]  function_byte, function_byte_next;
  logic [15:0] idle_ticks, idle_ticks_next;

  logic        res_valid;
  out_word_t   res;
  logic        adv;
  logic        push;
  logic        pop;

  logic [15:0] ticks_inc;
  logic [15:0] sum_add;
  logic [15:0] index_inc;
  logic [15:0] rx_sum;
  logic [7:0]  b;

  assign adv      = s1_valid && !k_valid;
  assign in_stall = s1_valid && k_valid;
  assign push     = adv && res_valid;
  assign pop      = out_valid && !out_stall;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
      max_length    <= MAX_LENGTH_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_TIMEOUT_TICKS: timeout_ticks <= cfg_data;
        REG_MAX_LENGTH:    max_length    <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!s1_valid || adv) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall && (!s1_valid || adv)) begin
      s1_data <= in_data;
    end
  end

  assign b         = s1_data.byte_value;
  assign ticks_inc = (idle_ticks == 16'hFFFF) ? idle_ticks : idle_ticks + 16'd1;
  assign sum_add   = running_sum + {8'd0, b};
  assign index_inc = byte_index + 16'd1;
  assign rx_sum    = {sum_high_byte, b};

  // frame state update for the word in the input register
  always_comb begin
    phase_next         = phase;
    byte_index_next    = byte_index;
    frame_length_next  = frame_length;
    running_sum_next   = running_sum;
    sum_high_byte_next = sum_high_byte;
    function_byte_next = function_byte;
    idle_ticks_next    = idle_ticks;
    res_valid          = 1'b0;
    res                = '0;
    res.function_code  = function_byte;

    if (s1_data.op == OP_TICK) begin
      idle_ticks_next = ticks_inc;
      if (phase != PH_IDLE && ticks_inc > timeout_ticks) begin
        res_valid       = 1'b1;
        res.kind        = KIND_END;
        res.status      = ST_TIMEOUT;
        res.last        = 1'b1;
        phase_next      = PH_IDLE;
        byte_index_next = '0;
        idle_ticks_next = '0;
      end
    end else begin
      case (phase)
        PH_IDLE: begin
          if (b == START_BYTE_0) begin
            phase_next         = PH_HEADER;
            byte_index_next    = 16'd1;
            running_sum_next   = {8'd0, b};
            function_byte_next = '0;
            frame_length_next  = '0;
            sum_high_byte_next = '0;
            idle_ticks_next    = '0;
          end
        end
        PH_HEADER: begin
          if (byte_index == 16'd1 && b != START_BYTE_1) begin
            phase_next      = PH_IDLE;
            byte_index_next = '0;
          end else begin
            if (byte_index == 16'd2) begin
              frame_length_next = {b, 8'd0};
            end else if (byte_index != 16'd1) begin
              frame_length_next = frame_length | {8'd0, b};
            end
            running_sum_next = sum_add;
            idle_ticks_next  = '0;
            byte_index_next  = index_inc;
            if (index_inc == HEADER_END) begin
              if (frame_length_next < MIN_LENGTH || frame_length_next > max_length) begin
                res_valid       = 1'b1;
                res.kind        = KIND_END;
                res.status      = ST_BAD_LENGTH;
                res.last        = 1'b1;
                phase_next      = PH_IDLE;
                byte_index_next = '0;
              end else begin
                phase_next = PH_BODY;
              end
            end
          end
        end
        PH_BODY: begin
          running_sum_next = sum_add;
          idle_ticks_next  = '0;
          if (byte_index == FUNCTION_INDEX) begin
            function_byte_next = b;
          end
          if (byte_index >= PAYLOAD_FIRST &&
              ({1'b0, byte_index} + {1'b0, TRAILER_BYTES}) <= {1'b0, frame_length}) begin
            res_valid        = 1'b1;
            res.kind         = KIND_PAYLOAD;
            res.payload_byte = b;
          end
          byte_index_next = index_inc;
          if (index_inc >= frame_length) begin
            phase_next = PH_SUM_HI;
          end
        end
        PH_SUM_HI: begin
          sum_high_byte_next = b;
          idle_ticks_next    = '0;
          phase_next         = PH_SUM_LO;
        end
        PH_SUM_LO: begin
          res_valid        = 1'b1;
          res.kind         = KIND_END;
          res.status       = (rx_sum == running_sum) ? ST_OK : ST_SUM_ERROR;
          res.computed_sum = running_sum;
          res.received_sum = rx_sum;
          res.last         = 1'b1;
          idle_ticks_next  = '0;
          phase_next       = PH_IDLE;
          byte_index_next  = '0;
        end
        default: begin
          phase_next      = PH_IDLE;
          byte_index_next = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      byte_index    <= '0;
      frame_length  <= '0;
      running_sum   <= '0;
      sum_high_byte <= '0;
      function_byte <= '0;
      idle_ticks    <= '0;
    end else if (adv) begin
      phase         <= phase_next;
      byte_index    <= byte_index_next;
      frame_length  <= frame_length_next;
      running_sum   <= running_sum_next;
      sum_high_byte <= sum_high_byte_next;
      function_byte <= function_byte_next;
      idle_ticks    <= idle_ticks_next;
    end
  end

  // output register and skid slot
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      k_valid   <= 1'b0;
    end else if (!out_valid || (pop && !k_valid)) begin
      out_valid <= push;
    end else if (pop) begin
      k_valid <= push;
    end else if (push) begin
      k_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || (pop && !k_valid)) begin
      if (push) begin
        out_data <= res;
      end
    end else if (pop) begin
      out_data <= k_data;
      if (push) begin
        k_data <= res;
      end
    end else if (push) begin
      k_data <= res;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !k_valid)
    else $error("skid slot full while output register empty");

  a_end_goes_idle: assert property (@(posedge clk) disable iff (rst)
    push && res.kind == KIND_END |=> phase == PH_IDLE)
    else $error("frame end word without return to idle");

  a_payload_in_body: assert property (@(posedge clk) disable iff (rst)
    push && res.kind == KIND_PAYLOAD |-> phase == PH_BODY)
    else $error("payload word outside frame body");

  a_body_index: assert property (@(posedge clk) disable iff (rst)
    phase == PH_BODY |-> byte_index < frame_length && frame_length >= MIN_LENGTH)
    else $error("body index past frame length");

endmodule

`default_nettype wire
